[src/sha256_pkg.sv]
package sha256_pkg;

   localparam int WordWidth = 32;
   localparam int BlockWords = 16;
   localparam int QueueDepth = 4;

   typedef logic [WordWidth-1:0] word_type;

   // front to back: one word to append, plus how to finish the block
   typedef struct packed {
      word_type word;
      logic     flush;
   } cmd_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_ROUND,
      BK_ADD,
      BK_OUT
   } back_state_type;

   typedef enum logic [2:0] {
      FR_IDLE,
      FR_MARK,
      FR_ZERO,
      FR_LEN_HI,
      FR_LEN_LO
   } front_state_type;

   localparam word_type InitHash [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam word_type RoundConst [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   function automatic word_type rotr(word_type x, int n);
      return (x >> n) | (x << (WordWidth - n));
   endfunction

endpackage

[src/sha256_front.sv]
module sha256_front (
   input  logic                clock,
   input  logic                reset,
   input  logic [31:0]         req_data_word,
   input  logic [2:0]          req_byte_count,
   input  logic                req_message_end,
   input  logic                req_valid,
   output logic                req_ready,
   output sha256_pkg::cmd_type cmd,
   output logic                cmd_valid,
   input  logic                cmd_ready
);
   import sha256_pkg::*;

   front_state_type state_ff, state_in;
   logic [3:0]  fill_ff, fill_in;
   logic [63:0] bits_ff, bits_in;
   logic [2:0]  cnt;
   word_type    mask, mark;

   always_comb begin
      cnt = (req_byte_count > 3'd4) ? 3'd4 : req_byte_count;
      case (cnt)
         3'd0: begin mask = 32'h00000000; mark = 32'h80000000; end
         3'd1: begin mask = 32'hff000000; mark = 32'h00800000; end
         3'd2: begin mask = 32'hffff0000; mark = 32'h00008000; end
         3'd3: begin mask = 32'hffffff00; mark = 32'h00000080; end
         default: begin mask = 32'hffffffff; mark = 32'h00000000; end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FR_IDLE;
         fill_ff  <= '0;
         bits_ff  <= '0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
         bits_ff  <= bits_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      fill_in   = fill_ff;
      bits_in   = bits_ff;
      req_ready = 1'b0;
      cmd_valid = 1'b0;
      cmd.word  = '0;
      cmd.flush = 1'b0;
      case (state_ff)
         FR_IDLE: begin
            req_ready = cmd_ready;
            cmd_valid = req_valid;
            if (req_message_end) begin
               cmd.word = (req_data_word & mask) | mark;
            end else begin
               cmd.word = req_data_word;
            end
            if (req_valid && cmd_ready) begin
               fill_in = fill_ff + 4'd1;
               if (req_message_end) begin
                  bits_in  = bits_ff + 64'(8 * cnt);
                  state_in = (cnt == 3'd4) ? FR_MARK : FR_ZERO;
               end else begin
                  bits_in = bits_ff + 64'd32;
               end
            end
         end
         FR_MARK: begin
            cmd_valid = 1'b1;
            cmd.word  = 32'h80000000;
            if (cmd_ready) begin
               fill_in  = fill_ff + 4'd1;
               state_in = FR_ZERO;
            end
         end
         FR_ZERO: begin
            // zero fill until two words remain, or past them into the next block
            if (fill_ff == 4'd14) begin
               state_in = FR_LEN_HI;
            end else begin
               cmd_valid = 1'b1;
               if (cmd_ready) fill_in = fill_ff + 4'd1;
            end
         end
         FR_LEN_HI: begin
            cmd_valid = 1'b1;
            cmd.word  = bits_ff[63:32];
            if (cmd_ready) begin
               fill_in  = fill_ff + 4'd1;
               state_in = FR_LEN_LO;
            end
         end
         FR_LEN_LO: begin
            cmd_valid = 1'b1;
            cmd.word  = bits_ff[31:0];
            cmd.flush = 1'b1;
            if (cmd_ready) begin
               fill_in  = '0;
               bits_in  = '0;
               state_in = FR_IDLE;
            end
         end
         default: state_in = FR_IDLE;
      endcase
   end

endmodule

[src/sha256_queue.sv]
module sha256_queue #(
   parameter int Depth = sha256_pkg::QueueDepth
) (
   input  logic                clock,
   input  logic                reset,
   input  sha256_pkg::cmd_type in_cmd,
   input  logic                in_valid,
   output logic                in_ready,
   output sha256_pkg::cmd_type out_cmd,
   output logic                out_valid,
   input  logic                out_ready
);
   import sha256_pkg::*;

   localparam int Aw = (Depth > 1) ? $clog2(Depth) : 1;

   cmd_type       mem_ff [Depth];
   logic [Aw-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [Aw:0]   cnt_ff, cnt_in;
   logic          push, pop;

   assign in_ready  = (cnt_ff != (Aw+1)'(Depth));
   assign out_valid = (cnt_ff != '0);
   assign out_cmd   = mem_ff[rd_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_in  = push ? ((wr_ff == Aw'(Depth-1)) ? '0 : wr_ff + 1'b1) : wr_ff;
      rd_in  = pop ? ((rd_ff == Aw'(Depth-1)) ? '0 : rd_ff + 1'b1) : rd_ff;
      cnt_in = cnt_ff + (Aw+1)'(push) - (Aw+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= in_cmd;
   end

endmodule

[src/sha256_back.sv]
module sha256_back (
   input  logic                clock,
   input  logic                reset,
   input  sha256_pkg::cmd_type cmd,
   input  logic                cmd_valid,
   output logic                cmd_ready,
   output logic [31:0]         rsp_digest_word,
   output logic [2:0]          rsp_digest_index,
   output logic                rsp_digest_last,
   output logic                rsp_valid,
   input  logic                rsp_ready
);
   import sha256_pkg::*;

   back_state_type state_ff, state_in;
   word_type   chain_ff [8];
   word_type   wv_ff [8];
   word_type   sched_ff [16];   // sliding message schedule window
   logic [3:0] fill_ff;
   logic [5:0] round_ff;
   logic       flush_ff;
   logic [2:0] idx_ff;
   word_type   w, s0, s1, wnext, t1, t2, big0, big1, ch, maj;
   logic       take;

   assign take = (state_ff == BK_IDLE) && cmd_valid;
   assign cmd_ready = (state_ff == BK_IDLE);
   assign rsp_valid = (state_ff == BK_OUT);
   assign rsp_digest_word  = chain_ff[idx_ff];
   assign rsp_digest_index = idx_ff;
   assign rsp_digest_last  = (idx_ff == 3'd7);

   always_comb begin
      w     = sched_ff[0];
      s0    = rotr(sched_ff[1], 7) ^ rotr(sched_ff[1], 18) ^ (sched_ff[1] >> 3);
      s1    = rotr(sched_ff[14], 17) ^ rotr(sched_ff[14], 19) ^ (sched_ff[14] >> 10);
      wnext = s1 + sched_ff[9] + s0 + sched_ff[0];
      big1  = rotr(wv_ff[4], 6) ^ rotr(wv_ff[4], 11) ^ rotr(wv_ff[4], 25);
      ch    = (wv_ff[4] & wv_ff[5]) ^ (~wv_ff[4] & wv_ff[6]);
      t1    = wv_ff[7] + big1 + ch + RoundConst[round_ff] + w;
      big0  = rotr(wv_ff[0], 2) ^ rotr(wv_ff[0], 13) ^ rotr(wv_ff[0], 22);
      maj   = (wv_ff[0] & wv_ff[1]) ^ (wv_ff[0] & wv_ff[2]) ^ (wv_ff[1] & wv_ff[2]);
      t2    = big0 + maj;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE:  if (take && fill_ff == 4'd15) state_in = BK_ROUND;
         BK_ROUND: if (round_ff == 6'd63) state_in = BK_ADD;
         BK_ADD:   state_in = flush_ff ? BK_OUT : BK_IDLE;
         BK_OUT:   if (rsp_ready && idx_ff == 3'd7) state_in = BK_IDLE;
         default:  state_in = BK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
         fill_ff  <= '0;
         round_ff <= '0;
         idx_ff   <= '0;
         flush_ff <= 1'b0;
         for (int i = 0; i < 8; i++) chain_ff[i] <= InitHash[i];
      end else begin
         state_ff <= state_in;
         case (state_ff)
            BK_IDLE: begin
               if (take) begin
                  fill_ff  <= fill_ff + 4'd1;
                  flush_ff <= cmd.flush;
                  round_ff <= '0;
               end
            end
            BK_ROUND: round_ff <= round_ff + 6'd1;
            BK_ADD: begin
               for (int i = 0; i < 8; i++) chain_ff[i] <= chain_ff[i] + wv_ff[i];
               idx_ff <= '0;
            end
            BK_OUT: begin
               if (rsp_ready) begin
                  idx_ff <= idx_ff + 3'd1;
                  if (idx_ff == 3'd7) begin
                     for (int i = 0; i < 8; i++) chain_ff[i] <= InitHash[i];
                  end
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         for (int i = 0; i < 15; i++) sched_ff[i] <= sched_ff[i+1];
         sched_ff[15] <= cmd.word;
         if (fill_ff == 4'd15) begin
            for (int i = 0; i < 8; i++) wv_ff[i] <= chain_ff[i];
         end
      end else if (state_ff == BK_ROUND) begin
         for (int i = 0; i < 15; i++) sched_ff[i] <= sched_ff[i+1];
         sched_ff[15] <= wnext;
         wv_ff[7] <= wv_ff[6];
         wv_ff[6] <= wv_ff[5];
         wv_ff[5] <= wv_ff[4];
         wv_ff[4] <= wv_ff[3] + t1;
         wv_ff[3] <= wv_ff[2];
         wv_ff[2] <= wv_ff[1];
         wv_ff[1] <= wv_ff[0];
         wv_ff[0] <= t1 + t2;
      end
   end

endmodule

[src/sha256_message_hasher_top.sv]
// throughput: one word per cycle while a block fills, unless the queue is full or the front is padding, then
// the 64 compression rounds and the chain update, during which the back end takes no word
// digest words go out one per cycle while rsp_ready is high
// synchronous reset loads the initial hash values and empties the word queue
module sha256_message_hasher_top #(
   parameter int QueueDepth = sha256_pkg::QueueDepth
) (
   input  logic        clock,
   input  logic        reset,
   input  logic [31:0] req_data_word,
   input  logic [2:0]  req_byte_count,
   input  logic        req_message_end,
   input  logic        req_valid,
   output logic        req_ready,
   output logic [31:0] rsp_digest_word,
   output logic [2:0]  rsp_digest_index,
   output logic        rsp_digest_last,
   output logic        rsp_valid,
   input  logic        rsp_ready
);
   import sha256_pkg::*;

   cmd_type f_cmd, b_cmd;
   logic    f_valid, f_ready, b_valid, b_ready;

   sha256_front u_front (
      .clock, .reset, .req_data_word, .req_byte_count, .req_message_end,
      .req_valid, .req_ready,
      .cmd(f_cmd), .cmd_valid(f_valid), .cmd_ready(f_ready)
   );

   sha256_queue #(.Depth(QueueDepth)) u_queue (
      .clock, .reset,
      .in_cmd(f_cmd), .in_valid(f_valid), .in_ready(f_ready),
      .out_cmd(b_cmd), .out_valid(b_valid), .out_ready(b_ready)
   );

   sha256_back u_back (
      .clock, .reset,
      .cmd(b_cmd), .cmd_valid(b_valid), .cmd_ready(b_ready),
      .rsp_digest_word, .rsp_digest_index, .rsp_digest_last,
      .rsp_valid, .rsp_ready
   );

endmodule

[sim/sha256_message_hasher_top_test.sv]
module sha256_message_hasher_top_test;
   import sha256_pkg::*;

   typedef struct {
      logic [31:0] data_word;
      logic [2:0]  byte_count;
      logic        message_end;
   } msg_item_type;

   typedef struct {
      logic [31:0] digest_word;
      logic [2:0]  digest_index;
      logic        digest_last;
   } digest_item_type;

   logic        clock = 0;
   logic        reset = 1;
   logic [31:0] req_data_word = '0;
   logic [2:0]  req_byte_count = '0;
   logic        req_message_end = 0;
   logic        req_valid = 0;
   logic        req_ready;
   logic [31:0] rsp_digest_word;
   logic [2:0]  rsp_digest_index;
   logic        rsp_digest_last;
   logic        rsp_valid;
   logic        rsp_ready = 0;

   msg_item_type    pending_words [$];
   digest_item_type expected_digests [$];

   // predictor state
   logic [31:0] hash_state [8];
   logic [31:0] block_buf [16];
   int unsigned fill_pos;
   logic [63:0] msg_bits;

   int error_count = 0;
   int words_sent = 0;
   int digests_seen = 0;
   int messages_sent = 0;
   bit quiet_phase = 0;       // no idling on either side
   bit hold_rsp = 0;          // long receiver hold-off
   bit pause_send = 0;
   int hold_cycles = 0;

   sha256_message_hasher_top DUT (.*);

   always #2 clock = ~clock;

   function automatic logic [31:0] ror32(logic [31:0] x, int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   task automatic run_compression();
      logic [31:0] w [64];
      logic [31:0] v [8];
      logic [31:0] s0, s1, t1, t2;
      for (int i = 0; i < 16; i++) w[i] = block_buf[i];
      for (int i = 16; i < 64; i++) begin
         s0 = ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3);
         s1 = ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10);
         w[i] = s1 + w[i-7] + s0 + w[i-16];
      end
      for (int i = 0; i < 8; i++) v[i] = hash_state[i];
      for (int r = 0; r < 64; r++) begin
         t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
            + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RoundConst[r] + w[r];
         t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
            + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
         v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
         v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++) hash_state[i] += v[i];
   endtask

   task automatic push_block_word(logic [31:0] w);
      block_buf[fill_pos] = w;
      fill_pos = (fill_pos + 1) % 16;
      if (fill_pos == 0) run_compression();
   endtask

   task automatic start_new_message();
      for (int i = 0; i < 8; i++) hash_state[i] = InitHash[i];
      fill_pos = 0;
      msg_bits = '0;
   endtask

   task automatic predict_digest(msg_item_type it);
      int unsigned n;
      logic [31:0] keep, mark;
      digest_item_type d;
      if (!it.message_end) begin
         msg_bits += 32;
         push_block_word(it.data_word);
         return;
      end
      n = (it.byte_count > 4) ? 4 : it.byte_count;
      keep = (n == 0) ? 32'h0 : ~(32'hffffffff >> (8 * n));
      mark = (n == 4) ? 32'h0 : (32'h80000000 >> (8 * n));
      msg_bits += 8 * n;
      push_block_word((it.data_word & keep) | mark);
      if (n == 4) push_block_word(32'h80000000);
      if (fill_pos > 14) push_block_word(32'h0);
      while (fill_pos < 14) push_block_word(32'h0);
      push_block_word(msg_bits[63:32]);
      push_block_word(msg_bits[31:0]);
      for (int i = 0; i < 8; i++) begin
         d.digest_word = hash_state[i];
         d.digest_index = i[2:0];
         d.digest_last = (i == 7);
         expected_digests.push_back(d);
      end
      start_new_message();
   endtask

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch on %s: got %h, expected %h", what, got, want);
      error_count++;
   endtask

   task automatic queue_word(logic [31:0] w, logic [2:0] bc, logic last);
      msg_item_type it;
      it.data_word = w;
      it.byte_count = bc;
      it.message_end = last;
      pending_words.push_back(it);
      if (last) messages_sent++;
   endtask

   // random message: mostly short, a few spanning several blocks
   task automatic queue_random_message();
      int len;
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(14, 40) : $urandom_range(0, 15);
      for (int i = 0; i < len; i++) queue_word($urandom, 3'($urandom), 1'b0);
      queue_word($urandom, 3'($urandom_range(0, 7)), 1'b1);
   endtask

   // driver
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) words_sent++;
         if (!(req_valid && !req_ready)) begin
            if (pending_words.size() > 0 && !pause_send
                && (quiet_phase || $urandom_range(0, 99) >= 13)) begin
               msg_item_type it;
               it = pending_words.pop_front();
               predict_digest(it);
               req_data_word <= it.data_word;
               req_byte_count <= it.byte_count;
               req_message_end <= it.message_end;
               req_valid <= 1;
            end else begin
               req_valid <= 0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            digests_seen++;
            if (expected_digests.size() == 0) begin
               report_mismatch("unexpected digest_word", rsp_digest_word, 32'h0);
            end else begin
               digest_item_type d;
               d = expected_digests.pop_front();
               if (rsp_digest_word !== d.digest_word)
                  report_mismatch("digest_word", rsp_digest_word, d.digest_word);
               if (rsp_digest_index !== d.digest_index)
                  report_mismatch("digest_index", 32'(rsp_digest_index),
                                  32'(d.digest_index));
               if (rsp_digest_last !== d.digest_last)
                  report_mismatch("digest_last", 32'(rsp_digest_last),
                                  32'(d.digest_last));
            end
         end
         if (hold_rsp) begin
            hold_cycles++;
            rsp_ready <= 0;
         end else begin
            rsp_ready <= quiet_phase || ($urandom_range(0, 99) >= 13);
         end
      end
   end

   initial begin
      #2000000;
      $display("simulation failed");
      $finish;
   end

   initial begin
      start_new_message();
      repeat (10) @(posedge clock);
      reset <= 0;

      // empty message, then byte counts zero to seven on single words
      queue_word(32'h0, 3'd0, 1'b1);
      for (int b = 0; b < 8; b++) queue_word(32'h61626364, b[2:0], 1'b1);
      // field extremes, non-last words with odd byte counts
      queue_word(32'hffffffff, 3'd7, 1'b0);
      queue_word(32'h00000000, 3'd0, 1'b0);
      queue_word(32'hffffffff, 3'd4, 1'b1);
      // full last word on the fourteenth and sixteenth position
      for (int i = 0; i < 13; i++) queue_word(32'hffffffff, 3'd7, 1'b0);
      queue_word(32'ha5a5a5a5, 3'd4, 1'b1);
      for (int i = 0; i < 15; i++) queue_word(i, 3'd0, 1'b0);
      queue_word(32'h5a5a5a5a, 3'd4, 1'b1);
      wait (pending_words.size() == 0 && expected_digests.size() == 0);

      // long receiver hold-off while the sender keeps going
      hold_rsp = 1;
      for (int m = 0; m < 6; m++) queue_random_message();
      wait (hold_cycles >= 600);
      hold_rsp = 0;
      wait (pending_words.size() == 0 && expected_digests.size() == 0);

      // sender pauses with a message queued, then resumes
      pause_send = 1;
      queue_random_message();
      repeat (200) @(posedge clock);
      pause_send = 0;

      while (words_sent + pending_words.size() < 110) queue_random_message();
      wait (pending_words.size() == 0);
      quiet_phase = 1;
      while (pending_words.size() < 50) queue_random_message();
      wait (pending_words.size() == 0);
      quiet_phase = 0;
      while (pending_words.size() < 50) queue_random_message();
      wait (pending_words.size() == 0);
      @(posedge clock);
      wait (!req_valid || req_ready);
      wait (expected_digests.size() == 0);
      repeat (200) @(posedge clock);

      $display("%0d messages, %0d words, %0d digest words checked",
               messages_sent, words_sent, digests_seen);
      $display("covered byte counts 0-7, block-boundary padding, stalls and hold-offs");
      if (error_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
